### src/tc_pkg.sv
// Package for the triangle classifier: widths, class codes and defaults.
// No dependencies; the files that use it refer to it by scoped names.
package tc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int CLASS_W = 3;
    localparam int LEN_W   = 25;
    localparam int PERIM_W = 27;
    localparam int AREA_W  = 33;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE      = 3'd0,
        CLS_EQUI      = 3'd1,
        CLS_RIGHT_ISO = 3'd2,
        CLS_ISO       = 3'd3,
        CLS_RIGHT     = 3'd4,
        CLS_SCALENE   = 3'd5
    } tri_class_t;

endpackage

### src/tc_if.sv
// Valid/ready channel interface used for both input and result words.
// Depends on nothing; payload width is a parameter.
interface tc_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/triangle_classifier_top.sv
// R = COORD_BITS+FRAC_BITS+1 is the number of root bits.
// Two difference/square stages, the root input register, ceil(R/2) root stages, output register.
// Throughput: one word per cycle when not stalled; the square-root pipeline sets the depth.
// A stall on the result side freezes the whole pipeline; an output register holds the word.
// Reset clears all valid bits; payload registers are not reset.
// Uses tc_pkg, tc_if, tc_diff, tc_sqrt, tc_classify.
module triangle_classifier_top #(
    parameter int COORD_BITS = tc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tc_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tc_if.sink   in_ch,
    tc_if.source out_ch
);
    localparam int SW   = 2 * COORD_BITS + 2;
    localparam int RADW = SW + 2 * FRAC_BITS;
    localparam int RW   = (RADW + 1) / 2;
    localparam int ST   = (RW + 1) / 2;
    localparam int LW   = tc_pkg::LEN_W;
    localparam int PW   = tc_pkg::PERIM_W;
    localparam int AW   = tc_pkg::AREA_W;
    localparam int CW   = tc_pkg::CLASS_W;

    logic en, d_valid, s_valid;
    logic [SW-1:0] ab2, ac2, bc2, area;
    logic [RW-1:0] rab, rac, rbc;
    logic [SW-1:0] area_d;
    logic [SW-1:0] unused_a, unused_b;
    tc_pkg::tri_class_t cls;

    logic          ov_reg;
    logic [CW-1:0] ocls_reg;
    logic [LW-1:0] oab_reg, oac_reg, obc_reg;
    logic [PW-1:0] oper_reg;
    logic [AW-1:0] oarea_reg;

    // advance whenever the output register is free or being drained
    assign en = !ov_reg || out_ch.ready;
    assign in_ch.ready = en;

    tc_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_ch.valid),
        .ax(in_ch.data[0*COORD_BITS +: COORD_BITS]),
        .ay(in_ch.data[1*COORD_BITS +: COORD_BITS]),
        .bx(in_ch.data[2*COORD_BITS +: COORD_BITS]),
        .by(in_ch.data[3*COORD_BITS +: COORD_BITS]),
        .cx(in_ch.data[4*COORD_BITS +: COORD_BITS]),
        .cy(in_ch.data[5*COORD_BITS +: COORD_BITS]),
        .out_valid(d_valid), .ab2(ab2), .ac2(ac2), .bc2(bc2), .area(area)
    );

    tc_sqrt #(.IN_W(RADW), .SIDE_W(SW)) u_sq_ab (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid),
        .rad(RADW'(ab2) << (2 * FRAC_BITS)), .side_in(area),
        .out_valid(s_valid), .root(rab), .side_out(area_d)
    );
    tc_sqrt #(.IN_W(RADW), .SIDE_W(SW)) u_sq_ac (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid),
        .rad(RADW'(ac2) << (2 * FRAC_BITS)), .side_in(ac2),
        .out_valid(), .root(rac), .side_out(unused_a)
    );
    tc_sqrt #(.IN_W(RADW), .SIDE_W(SW)) u_sq_bc (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid),
        .rad(RADW'(bc2) << (2 * FRAC_BITS)), .side_in(bc2),
        .out_valid(), .root(rbc), .side_out(unused_b)
    );

    tc_classify #(.SW(SW), .DELAY(ST + 1)) u_cls (
        .clk(clk), .en(en), .ab2(ab2), .ac2(ac2), .bc2(bc2), .area(area), .cls(cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ocls_reg  <= CW'(cls);
            oab_reg   <= LW'(rab);
            oac_reg   <= LW'(rac);
            obc_reg   <= LW'(rbc);
            oper_reg  <= PW'(PW'(rab) + PW'(rac) + PW'(rbc));
            oarea_reg <= AW'(area_d);
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = {oarea_reg, oper_reg, obc_reg, oac_reg, oab_reg, ocls_reg};
endmodule

### src/tc_diff.sv
// Stage 1 and 2: coordinate differences, then squared distances and cross terms.
// Uses tc_pkg.
module tc_diff #(
    parameter int COORD_BITS = tc_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         out_valid,
    output logic [2*COORD_BITS+1:0]      ab2,
    output logic [2*COORD_BITS+1:0]      ac2,
    output logic [2*COORD_BITS+1:0]      bc2,
    output logic [2*COORD_BITS+1:0]      area
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * COORD_BITS + 2;

    logic signed [DW-1:0] dabx_reg, daby_reg, dacx_reg, dacy_reg, dbcx_reg, dbcy_reg;
    logic                 v1_reg, v2_reg;
    logic [SW-1:0]        ab2_reg, ac2_reg, bc2_reg;
    logic [SW-1:0]        area_reg;
    logic signed [SW:0]   xprod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // cross product from the stage-1 differences, same stage as the squares
    always_comb
    begin
        xprod = (SW+1)'(dabx_reg) * (SW+1)'(dacy_reg)
              - (SW+1)'(daby_reg) * (SW+1)'(dacx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dabx_reg <= DW'(bx) - DW'(ax);
            daby_reg <= DW'(by) - DW'(ay);
            dacx_reg <= DW'(cx) - DW'(ax);
            dacy_reg <= DW'(cy) - DW'(ay);
            dbcx_reg <= DW'(cx) - DW'(bx);
            dbcy_reg <= DW'(cy) - DW'(by);
            // squares of a signed value are non-negative, sum fits SW bits
            ab2_reg  <= SW'(SW'(dabx_reg) * SW'(dabx_reg) + SW'(daby_reg) * SW'(daby_reg));
            ac2_reg  <= SW'(SW'(dacx_reg) * SW'(dacx_reg) + SW'(dacy_reg) * SW'(dacy_reg));
            bc2_reg  <= SW'(SW'(dbcx_reg) * SW'(dbcx_reg) + SW'(dbcy_reg) * SW'(dbcy_reg));
            area_reg <= xprod[SW] ? SW'(-xprod) : SW'(xprod);
        end
    end

    assign out_valid = v2_reg;
    assign ab2  = ab2_reg;
    assign ac2  = ac2_reg;
    assign bc2  = bc2_reg;
    assign area = area_reg;
endmodule

### src/tc_sqrt.sv
// Pipelined restoring square root, two result bits resolved per stage.
// Carries a side payload along with each word.
module tc_sqrt #(
    parameter int IN_W  = 36,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [IN_W-1:0]       rad,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [(IN_W+1)/2-1:0] root,
    output logic [SIDE_W-1:0]     side_out
);
    localparam int RW = (IN_W + 1) / 2;
    localparam int NW = 2 * RW;
    localparam int ST = (RW + 1) / 2;

    logic [NW-1:0]     rem_reg  [ST+1];
    logic [RW-1:0]     res_reg  [ST+1];
    logic [SIDE_W-1:0] side_reg [ST+1];
    logic [ST:0]       v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ST-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= NW'(rad);
            res_reg[0]  <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar s = 0; s < ST; s++)
    begin : g_stage
        logic [NW-1:0] rem_n;
        logic [RW-1:0] res_n;
        always_comb
        begin
            logic [NW+1:0] trial;
            rem_n = rem_reg[s];
            res_n = res_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                if (2 * s + k < RW)
                begin
                    // bit position of this result digit, MSB first
                    trial = ({2'b00, NW'(res_n)} << (RW - (2 * s + k)))
                          + ({2'b00, NW'(1)} << (2 * (RW - 1 - (2 * s + k))));
                    if ({2'b00, rem_n} >= trial)
                    begin
                        rem_n = NW'({2'b00, rem_n} - trial);
                        res_n = res_n | (RW'(1) << (RW - 1 - (2 * s + k)));
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1]  <= rem_n;
                res_reg[s+1]  <= res_n;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = v_reg[ST];
    assign root      = res_reg[ST];
    assign side_out  = side_reg[ST];
endmodule

### src/tc_classify.sv
// Classification on squared lengths and the area term, registered, then a delay line to
// match the square-root pipeline. Uses tc_pkg.
module tc_classify #(
    parameter int SW    = 34,
    parameter int DELAY = 4
) (
    input  logic               clk,
    input  logic               en,
    input  logic [SW-1:0]      ab2,
    input  logic [SW-1:0]      ac2,
    input  logic [SW-1:0]      bc2,
    input  logic [SW-1:0]      area,
    output tc_pkg::tri_class_t cls
);
    tc_pkg::tri_class_t cls_next;
    tc_pkg::tri_class_t cls_reg [DELAY];
    logic eq1, eq2, eq3, equi, iso, right;

    always_comb
    begin
        eq1   = (ab2 == ac2);
        eq2   = (ab2 == bc2);
        eq3   = (ac2 == bc2);
        equi  = eq1 && eq3;
        iso   = eq1 || eq2 || eq3;
        right = ({1'b0, ab2} == {1'b0, ac2} + {1'b0, bc2})
             || ({1'b0, ac2} == {1'b0, ab2} + {1'b0, bc2})
             || ({1'b0, bc2} == {1'b0, ab2} + {1'b0, ac2});
        if (area == '0)
            cls_next = tc_pkg::CLS_NONE;
        else if (equi)
            cls_next = tc_pkg::CLS_EQUI;
        else if (right && iso)
            cls_next = tc_pkg::CLS_RIGHT_ISO;
        else if (iso)
            cls_next = tc_pkg::CLS_ISO;
        else if (right)
            cls_next = tc_pkg::CLS_RIGHT;
        else
            cls_next = tc_pkg::CLS_SCALENE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg[0] <= cls_next;
            for (int i = 1; i < DELAY; i++)
                cls_reg[i] <= cls_reg[i-1];
        end
    end

    assign cls = cls_reg[DELAY-1];
endmodule

### src/tc_checker.sv
// Port-level checks for the triangle classifier, bound to the top level.
// Uses tc_pkg for the class codes and field widths.
module tc_checker #(
    parameter int OW = 138
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [OW-1:0] out_data
);
    localparam int CW = tc_pkg::CLASS_W;
    localparam int LW = tc_pkg::LEN_W;
    localparam int PW = tc_pkg::PERIM_W;

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data[CW-1:0] <= CW'(tc_pkg::CLS_SCALENE))
        else $error("class code out of range");

    a_flat_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data[OW-1 -: tc_pkg::AREA_W] == '0
        |-> out_data[CW-1:0] == CW'(tc_pkg::CLS_NONE))
        else $error("zero area word not classed as none");

    a_perim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data[CW+3*LW +: PW] ==
            PW'(out_data[CW +: LW]) + PW'(out_data[CW+LW +: LW])
            + PW'(out_data[CW+2*LW +: LW]))
        else $error("perimeter does not match side lengths");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule

bind triangle_classifier_top tc_checker #(
    .OW(tc_pkg::CLASS_W + 3 * tc_pkg::LEN_W + tc_pkg::PERIM_W + tc_pkg::AREA_W)
) u_tc_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);

### bench/triangle_classifier_top_tb.sv
// Self-checking bench for triangle_classifier_top: directed table, then random vertex triples.
// Depends on tc_pkg and tc_if from the RTL; predicts every result word and compares it in order.
module triangle_classifier_top_tb;

    localparam int CB      = tc_pkg::COORD_BITS_DEF;
    localparam int FB      = tc_pkg::FRAC_BITS_DEF;
    localparam int LEN_W   = tc_pkg::LEN_W;
    localparam int PERIM_W = tc_pkg::PERIM_W;
    localparam int AREA_W  = tc_pkg::AREA_W;
    localparam int N_RAND  = 930;
    localparam int N_TAIL  = 120;
    localparam int DRAIN   = 40;

    // first vertex sits in the low bits of the word
    typedef struct packed {
        logic signed [CB-1:0] cy;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] by;
        logic signed [CB-1:0] bx;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] ax;
    } verts_t;

    // class code sits in the low bits of the word
    typedef struct packed {
        logic [AREA_W-1:0]  area_doubled;
        logic [PERIM_W-1:0] perimeter;
        logic [LEN_W-1:0]   len_bc;
        logic [LEN_W-1:0]   len_ac;
        logic [LEN_W-1:0]   len_ab;
        tc_pkg::tri_class_t cls;
    } tri_res_t;

    typedef struct {
        verts_t   v;
        bit       typed;
        tri_res_t res;
    } row_t;

    logic clk;
    logic rst_n;

    tc_if #(.W($bits(verts_t)))   in_ch ();
    tc_if #(.W($bits(tri_res_t))) out_ch ();

    triangle_classifier_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    tri_res_t expected_q[$];
    int       mismatches;
    bit       no_idle;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n   -= res + b;
                res  = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned dist_sq(longint x0, longint y0, longint x1, longint y1);
        longint dx;
        longint dy;
        dx = x1 - x0;
        dy = y1 - y0;
        return dx * dx + dy * dy;
    endfunction

    function automatic tri_res_t classify_tri(verts_t v);
        longint          ax, ay, bx, by, cx, cy, xprod;
        longint unsigned ab2, ac2, bc2, lab, lac, lbc;
        bit              equi, iso, rt;
        tri_res_t        r;
        ax = v.ax; ay = v.ay; bx = v.bx; by = v.by; cx = v.cx; cy = v.cy;
        ab2 = dist_sq(ax, ay, bx, by);
        ac2 = dist_sq(ax, ay, cx, cy);
        bc2 = dist_sq(bx, by, cx, cy);
        xprod = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        lab = int_sqrt(ab2 << (2 * FB));
        lac = int_sqrt(ac2 << (2 * FB));
        lbc = int_sqrt(bc2 << (2 * FB));
        equi = (ab2 == ac2) && (ac2 == bc2);
        iso  = (ab2 == ac2) || (ab2 == bc2) || (ac2 == bc2);
        rt   = (ab2 == ac2 + bc2) || (ac2 == ab2 + bc2) || (bc2 == ab2 + ac2);
        if (xprod == 0)
            r.cls = tc_pkg::CLS_NONE;
        else if (equi)
            r.cls = tc_pkg::CLS_EQUI;
        else if (rt && iso)
            r.cls = tc_pkg::CLS_RIGHT_ISO;
        else if (iso)
            r.cls = tc_pkg::CLS_ISO;
        else if (rt)
            r.cls = tc_pkg::CLS_RIGHT;
        else
            r.cls = tc_pkg::CLS_SCALENE;
        r.len_ab       = lab[LEN_W-1:0];
        r.len_ac       = lac[LEN_W-1:0];
        r.len_bc       = lbc[LEN_W-1:0];
        r.perimeter    = PERIM_W'(lab + lac + lbc);
        r.area_doubled = AREA_W'(xprod < 0 ? -xprod : xprod);
        return r;
    endfunction

    function automatic verts_t mk(int ax, int ay, int bx, int by, int cx, int cy);
        verts_t v;
        v.ax = CB'(ax); v.ay = CB'(ay); v.bx = CB'(bx);
        v.by = CB'(by); v.cx = CB'(cx); v.cy = CB'(cy);
        return v;
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly shaped triples so the rarer classes turn up, plus plain noise.
    function automatic verts_t random_tri();
        int ax, ay, p, q, k, mode;
        mode = $urandom_range(0, 9);
        ax = srand(32768);
        ay = srand(32768);
        p  = srand(300);
        q  = srand(300);
        k  = srand(4);
        case (mode)
            0, 1, 2: return verts_t'({$urandom(), $urandom(), $urandom()});
            3, 4:    return mk(ax, ay, ax + srand(3), ay + srand(3), ax + srand(3), ay + srand(3));
            5, 6:    return mk(ax, ay, ax + p, ay + q, ax - k * q, ay + k * p);
            7:       return mk(ax, ay, ax + p, ay + q, ax + k * p, ay + k * q);
            8:       return mk(ax, ay, ax + p, ay + q, ax + q, ay + p);
            default: return mk(ax, ay, ax + p, ay + q, ax - p, ay + q);
        endcase
    endfunction

    task automatic send_tri(verts_t v, bit typed, tri_res_t res);
        bit taken;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= v;
        taken = 1'b0;
        while (!taken)
        begin
            #1 taken = in_ch.ready;
            @(posedge clk);
            if (taken)
                expected_q.push_back(typed ? res : classify_tri(v));
            @(negedge clk);
        end
    endtask

    task automatic report(string what, longint unsigned exp_v, longint unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // Result side: stall in bursts, compare each word against the oldest prediction.
    initial
    begin
        tri_res_t got, exp_r;
        bit       fire;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            #1 fire = out_ch.valid && out_ch.ready;
            got = out_ch.data;
            @(posedge clk);
            if (fire)
            begin
                if (expected_q.size() == 0)
                    report("unexpected word, class", 0, got.cls);
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.cls != exp_r.cls)
                        report("tri_class", exp_r.cls, got.cls);
                    if (got.len_ab != exp_r.len_ab)
                        report("len_ab", exp_r.len_ab, got.len_ab);
                    if (got.len_ac != exp_r.len_ac)
                        report("len_ac", exp_r.len_ac, got.len_ac);
                    if (got.len_bc != exp_r.len_bc)
                        report("len_bc", exp_r.len_bc, got.len_bc);
                    if (got.perimeter != exp_r.perimeter)
                        report("perimeter", exp_r.perimeter, got.perimeter);
                    if (got.area_doubled != exp_r.area_doubled)
                        report("area_doubled", exp_r.area_doubled, got.area_doubled);
                end
            end
        end
    end

    initial
    begin
        row_t dir_rows[$];
        row_t row;
        tri_res_t none_r;
        mismatches  = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        none_r = '{0, 0, 0, 0, 0, tc_pkg::CLS_NONE};

        // coincident points: nothing but zeros
        dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1'b1, none_r});
        dir_rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768), 1'b1, none_r});
        // unit right isosceles: sqrt(2) truncates to 362/256
        dir_rows.push_back('{mk(0, 0, 1, 0, 0, 1), 1'b1,
                             '{1, 874, 362, 256, 256, tc_pkg::CLS_RIGHT_ISO}});
        dir_rows.push_back('{mk(0, 0, 3, 0, 0, 4), 1'b1,
                             '{12, 3072, 1280, 1024, 768, tc_pkg::CLS_RIGHT}});
        dir_rows.push_back('{mk(0, 0, 2, 0, 1, 5), 1'b0, none_r});
        dir_rows.push_back('{mk(0, 0, 2, 0, 7, 3), 1'b0, none_r});
        dir_rows.push_back('{mk(1, 1, 2, 2, 5, 5), 1'b0, none_r});
        dir_rows.push_back('{mk(-32768, 0, 32767, 0, 0, 0), 1'b0, none_r});
        dir_rows.push_back('{mk(-32768, -32768, 32767, -32768, -32768, 32767), 1'b0, none_r});
        dir_rows.push_back('{mk(-32768, -32768, 32767, 32767, -32768, 32767), 1'b0, none_r});
        dir_rows.push_back('{mk(32767, 32767, -32768, -32768, 32767, -32768), 1'b0, none_r});
        dir_rows.push_back('{mk(-32768, 32767, 32767, -32768, 32767, 32767), 1'b0, none_r});
        dir_rows.push_back('{mk(-1, -1, 0, 0, -1, 0), 1'b0, none_r});
        dir_rows.push_back('{mk(0, 32767, -32768, 0, 32767, -32768), 1'b0, none_r});
        dir_rows.push_back('{mk(5, 5, 5, 5, 9, 1), 1'b0, none_r});
        dir_rows.push_back('{mk(-5, 0, 5, 0, 0, 9), 1'b0, none_r});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_tri(row.v, row.typed, row.res);
        end
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == N_RAND - N_TAIL)
                no_idle = 1'b1;
            send_tri(random_tri(), 1'b0, none_r);
        end
        in_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
